[src/union_find_by_rank_macros.svh]
// ----------------------------------------------------------------------------
// Union-find engine assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_BY_RANK_MACROS_SVH
`define UNION_FIND_BY_RANK_MACROS_SVH

`ifndef SYNTH
// Assertion on an explicit clock and reset.
`define UFR_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion on the block clock and reset.
`define UFR_ASSERT(lbl, prop, msg) \
   `UFR_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define UFR_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define UFR_ASSERT(lbl, prop, msg)
`endif

`endif

[src/ufr_pkg.sv]
// ----------------------------------------------------------------------------
// Union-find engine package
// Field widths, rank limits and operation codes shared by the channel
// interfaces and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufr_pkg;

   localparam int unsigned NODE_W = 8;
   localparam int unsigned RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   typedef enum logic {
      OP_QUERY = 1'b0,
      OP_UNION = 1'b1
   } op_type;

endpackage

`default_nettype wire

[src/ufr_if.sv]
// ----------------------------------------------------------------------------
// Union-find engine channels
// Valid/ready request and response channels of the union-find engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufr_req_if import ufr_pkg::*; ();
   logic              valid;
   logic              ready;
   op_type            operation;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;

   modport source (output valid, output operation, output node_a, output node_b,
                   input ready);
   modport sink (input valid, input operation, input node_a, input node_b,
                 output ready);
endinterface

interface ufr_rsp_if import ufr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] root_a;
   logic [NODE_W-1:0] root_b;
   logic              same_set;
   logic              merged;
   logic [NODE_W-1:0] new_root;

   modport source (output valid, output root_a, output root_b, output same_set,
                   output merged, output new_root, input ready);
   modport sink (input valid, input root_a, input root_b, input same_set,
                 input merged, input new_root, output ready);
endinterface

`default_nettype wire

[src/union_find_by_rank.sv]
// ----------------------------------------------------------------------------
// Union-find engine
// Disjoint-set forest with union by rank and path compression, kept in a
// parent memory and a rank memory and served by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over all NODES entries, writing every
// parent entry to its own index and every rank to zero; no request is taken
// during that pass. Each request is then accepted, and for each of its two nodes
// (node_a first) the engine follows pointers to the root, reading one parent per
// step, then rewrites the visited nodes to point at the root by path compression.
// A union of two distinct sets then reads both ranks and links, and every request
// ends by loading the response register, which waits while an earlier response
// is still untaken. With union by rank the find depth never exceeds log2(NODES).
// Every pointer hop waits on the single, registered read port of the parent memory.
// Node indexes at or above NODES are reduced modulo NODES, and roots wider than
// eight bits are reported in their low eight bits. The response sits in an
// output register, so the next request is accepted while it waits to be taken.
`default_nettype none

`include "union_find_by_rank_macros.svh"

module union_find_by_rank import ufr_pkg::*; #(
   parameter int unsigned NODES = 256
) (
   input  wire        clock,
   input  wire        reset,
   ufr_req_if.sink    req_ch,
   ufr_rsp_if.source  rsp_ch
);

   // Index width of the forest, and a width that covers both it and the ports.
   localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int unsigned OW = (NW > NODE_W) ? NW : NODE_W;

   typedef logic [NW-1:0]     idx_type;
   typedef logic [RANK_W-1:0] rank_type;

   localparam idx_type IDX_LAST = NW'(NODES - 1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FIND  = 7'b0000100,
      ST_COMP  = 7'b0001000,
      ST_RANK  = 7'b0010000,
      ST_LINK  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   // Modulo reduction of an incoming eight-bit node index, as a constant table.
   idx_type node_mod [256];

   for (genvar g = 0; g < 256; g++) begin : g_mod
      localparam int unsigned MODV = g % NODES;
      assign node_mod[g] = NW'(MODV);
   end

   // Sequencer state.
   state_type state_ff, state_in;
   logic      side_ff, side_in;          // 0 while resolving node_a, 1 for node_b
   op_type    op_ff, op_in;
   idx_type   start_a_ff, start_a_in;
   idx_type   start_b_ff, start_b_in;
   idx_type   cur_ff, cur_in;            // node whose parent is being read
   idx_type   root_ff, root_in;          // root of the find in progress
   idx_type   root_a_ff, root_a_in;
   idx_type   root_b_ff, root_b_in;
   idx_type   new_root_ff, new_root_in;
   logic      same_ff, same_in;
   logic      merged_ff, merged_in;
   rank_type  rank_a_ff, rank_a_in;
   idx_type   clr_cnt_ff, clr_cnt_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_root_a_ff, rsp_root_a_in;
   logic [NODE_W-1:0] rsp_root_b_ff, rsp_root_b_in;
   logic              rsp_same_ff, rsp_same_in;
   logic              rsp_merged_ff, rsp_merged_in;
   logic [NODE_W-1:0] rsp_new_root_ff, rsp_new_root_in;

   // Parent memory port.
   idx_type parent_mem [NODES];
   idx_type pr_addr;
   idx_type pr_data_ff;
   logic    pw_en;
   idx_type pw_addr;
   idx_type pw_data;

   // Rank memory port.
   rank_type rank_mem [NODES];
   idx_type  kr_addr;
   rank_type kr_data_ff;
   logic     kw_en;
   idx_type  kw_addr;
   rank_type kw_data;

   // Sequencer helpers.
   logic    req_fire;
   logic    fin;
   idx_type fin_root;
   idx_type start_cur;
   logic    same_now;
   logic [OW-1:0] wide_ra;
   logic [OW-1:0] wide_rb;
   logic [OW-1:0] wide_nr;

   assign req_fire  = req_ch.valid && (state_ff == ST_IDLE);
   assign start_cur = side_ff ? start_b_ff : start_a_ff;

   assign wide_ra = OW'(root_a_ff);
   assign wide_rb = OW'(root_b_ff);
   assign wide_nr = OW'(new_root_ff);

   always_comb begin
      state_in        = state_ff;
      side_in         = side_ff;
      op_in           = op_ff;
      start_a_in      = start_a_ff;
      start_b_in      = start_b_ff;
      cur_in          = cur_ff;
      root_in         = root_ff;
      root_a_in       = root_a_ff;
      root_b_in       = root_b_ff;
      new_root_in     = new_root_ff;
      same_in         = same_ff;
      merged_in       = merged_ff;
      rank_a_in       = rank_a_ff;
      clr_cnt_in      = clr_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_root_a_in   = rsp_root_a_ff;
      rsp_root_b_in   = rsp_root_b_ff;
      rsp_same_in     = rsp_same_ff;
      rsp_merged_in   = rsp_merged_ff;
      rsp_new_root_in = rsp_new_root_ff;
      pr_addr         = cur_ff;
      pw_en           = 1'b0;
      pw_addr         = cur_ff;
      pw_data         = root_ff;
      kr_addr         = root_a_ff;
      kw_en           = 1'b0;
      kw_addr         = root_a_ff;
      kw_data         = '0;
      fin             = 1'b0;
      fin_root        = root_ff;
      same_now        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            pw_en      = 1'b1;
            pw_addr    = clr_cnt_ff;
            pw_data    = clr_cnt_ff;
            kw_en      = 1'b1;
            kw_addr    = clr_cnt_ff;
            kw_data    = '0;
            clr_cnt_in = clr_cnt_ff + NW'(1);
            if (clr_cnt_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in      = req_ch.operation;
               start_a_in = node_mod[req_ch.node_a];
               start_b_in = node_mod[req_ch.node_b];
               cur_in     = node_mod[req_ch.node_a];
               pr_addr    = node_mod[req_ch.node_a];
               side_in    = 1'b0;
               state_in   = ST_FIND;
            end
         end
         ST_FIND: begin
            // The parent of cur_ff has arrived; a self pointer marks the root.
            if (pr_data_ff == cur_ff) begin
               root_in = cur_ff;
               if (cur_ff == start_cur) begin
                  fin      = 1'b1;
                  fin_root = cur_ff;
               end else begin
                  pr_addr  = start_cur;
                  cur_in   = start_cur;
                  state_in = ST_COMP;
               end
            end else begin
               pr_addr = pr_data_ff;
               cur_in  = pr_data_ff;
            end
         end
         ST_COMP: begin
            // Point cur_ff straight at the root while its old parent is read next.
            pw_en = 1'b1;
            if (pr_data_ff == root_ff) begin
               fin      = 1'b1;
               fin_root = root_ff;
            end else begin
               pr_addr = pr_data_ff;
               cur_in  = pr_data_ff;
            end
         end
         ST_RANK: begin
            rank_a_in = kr_data_ff;
            kr_addr   = root_b_ff;
            state_in  = ST_LINK;
         end
         ST_LINK: begin
            merged_in = 1'b1;
            pw_en     = 1'b1;
            if (rank_a_ff < kr_data_ff) begin
               pw_addr     = root_a_ff;
               pw_data     = root_b_ff;
               new_root_in = root_b_ff;
            end else begin
               pw_addr     = root_b_ff;
               pw_data     = root_a_ff;
               new_root_in = root_a_ff;
            end
            // Equal ranks: the first root gains a level, saturating at the top.
            if ((rank_a_ff == kr_data_ff) && (rank_a_ff != RANK_MAX)) begin
               kw_en   = 1'b1;
               kw_addr = root_a_ff;
               kw_data = rank_a_ff + RANK_W'(1);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_root_a_in   = wide_ra[NODE_W-1:0];
               rsp_root_b_in   = wide_rb[NODE_W-1:0];
               rsp_same_in     = same_ff;
               rsp_merged_in   = merged_ff;
               rsp_new_root_in = wide_nr[NODE_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // End of one node's find and compression.
      if (fin) begin
         if (!side_ff) begin
            root_a_in = fin_root;
            side_in   = 1'b1;
            cur_in    = start_b_ff;
            pr_addr   = start_b_ff;
            state_in  = ST_FIND;
         end else begin
            same_now    = (root_a_ff == fin_root);
            root_b_in   = fin_root;
            same_in     = same_now;
            merged_in   = 1'b0;
            new_root_in = ((op_ff == OP_UNION) || same_now) ? root_a_ff : '0;
            if ((op_ff == OP_UNION) && !same_now) begin
               kr_addr  = root_a_ff;
               state_in = ST_RANK;
            end else begin
               state_in = ST_RESP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff         <= side_in;
      op_ff           <= op_in;
      start_a_ff      <= start_a_in;
      start_b_ff      <= start_b_in;
      cur_ff          <= cur_in;
      root_ff         <= root_in;
      root_a_ff       <= root_a_in;
      root_b_ff       <= root_b_in;
      new_root_ff     <= new_root_in;
      same_ff         <= same_in;
      merged_ff       <= merged_in;
      rank_a_ff       <= rank_a_in;
      rsp_root_a_ff   <= rsp_root_a_in;
      rsp_root_b_ff   <= rsp_root_b_in;
      rsp_same_ff     <= rsp_same_in;
      rsp_merged_ff   <= rsp_merged_in;
      rsp_new_root_ff <= rsp_new_root_in;
   end

   // Parent memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (pw_en) begin
         parent_mem[pw_addr] <= pw_data;
      end
      pr_data_ff <= parent_mem[pr_addr];
   end

   // Rank memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (kw_en) begin
         rank_mem[kw_addr] <= kw_data;
      end
      kr_data_ff <= rank_mem[kr_addr];
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.root_a   = rsp_root_a_ff;
   assign rsp_ch.root_b   = rsp_root_b_ff;
   assign rsp_ch.same_set = rsp_same_ff;
   assign rsp_ch.merged   = rsp_merged_ff;
   assign rsp_ch.new_root = rsp_new_root_ff;

   // Compression never rewrites the root itself.
   `UFR_ASSERT(a_comp_not_root, (state_ff == ST_COMP) |-> (cur_ff != root_ff), "compression reached the root")
   // Linking only happens between two distinct roots.
   `UFR_ASSERT(a_link_distinct, (state_ff == ST_LINK) |-> (root_a_ff != root_b_ff), "link of a root to itself")
   // A response never claims a merge of nodes that already shared a root.
   `UFR_ASSERT(a_merge_excl, rsp_ch.valid |-> !(rsp_ch.merged && rsp_ch.same_set), "merged and same_set both set")

endmodule

`default_nettype wire
